// ----- rtl/keyword_severity_scanner_top_defines.svh -----
// Assertion macros for the keyword severity scanner.
`ifndef KEYWORD_SEVERITY_SCANNER_TOP_DEFINES_SVH
`define KEYWORD_SEVERITY_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KSS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyword severity scanner check failed");
`define KSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyword severity scanner check failed");
`else
`define KSS_ASSERT_SAME(lbl, ante, cons)
`define KSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/kss_pkg.sv -----
// Shared types, keyword table and severity codes for the keyword severity scanner.
`default_nettype none

package kss_pkg;

    localparam int TERM_COUNT   = 11;
    localparam int URGENT_COUNT = 6;
    localparam int TERM_MAX     = 15;

    // Right-justified text: bits [7:0] hold the last letter of the term.
    localparam logic [TERM_MAX*8-1:0] TERM_TXT [TERM_COUNT] = '{
        "chest pain", "suicidal", "overdose", "can't breathe", "cannot breathe",
        "stroke",
        "diagnose", "prescribe", "stop medication", "dosage", "pregnant"
    };

    localparam int TERM_LEN [TERM_COUNT] = '{10, 8, 8, 13, 14, 6, 8, 9, 15, 6, 8};

    localparam logic [1:0] SEV_OK      = 2'd0;
    localparam logic [1:0] SEV_CAUTION = 2'd1;
    localparam logic [1:0] SEV_URGENT  = 2'd2;

    typedef struct packed {
        logic urgent;
        logic caution;
    } t_hits;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kss_match.sv -----
// Parallel comparison of the current byte and byte history against every keyword.
`default_nettype none

module kss_match (
    input  logic [7:0]                          i_cur,
    input  logic [kss_pkg::TERM_MAX-2:0][7:0]   i_window,
    output kss_pkg::t_hits                      o_hits
);

    always_comb begin
        logic [kss_pkg::TERM_COUNT-1:0] hit;
        hit = '0;
        for (int t = 0; t < kss_pkg::TERM_COUNT; t++) begin
            hit[t] = (i_cur == kss_pkg::TERM_TXT[t][7:0]);
            // older letters line up with the window, most recent first
            for (int k = 1; k < kss_pkg::TERM_MAX; k++) begin
                if (k < kss_pkg::TERM_LEN[t] &&
                    i_window[k-1] != kss_pkg::TERM_TXT[t][k*8 +: 8]) begin
                    hit[t] = 1'b0;
                end
            end
        end
        o_hits.urgent  = |hit[kss_pkg::URGENT_COUNT-1:0];
        o_hits.caution = |hit[kss_pkg::TERM_COUNT-1:kss_pkg::URGENT_COUNT];
    end

endmodule

`default_nettype wire

// ----- rtl/keyword_severity_scanner_top.sv -----
// Top level of the keyword severity scanner: input register, history window, result register.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_character, i_has_character, i_last
//  out      output     o_out_valid / i_out_stall  o_severity
//
//  One word is taken every cycle while o_in_stall is low; the keyword compare is a single pass between the
//  input register and the window/result registers.
//  o_out_valid is registered; it rises as the word marked last leaves the input register.
//  Reset (synchronous, active low) clears the window, the match flags and both valids.
//  Only a word marked last waits on a full, stalled result register; others never stall.
`default_nettype none

module keyword_severity_scanner_top #(
    parameter int HISTORY_DEPTH = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_character,
    input  logic       i_has_character,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_severity
);

`include "keyword_severity_scanner_top_defines.svh"

    logic                           r_a_valid;
    logic [7:0]                     r_a_char;
    logic                           r_a_has;
    logic                           r_a_last;
    logic [HISTORY_DEPTH-1:0][7:0]  r_window;
    logic [HISTORY_DEPTH-1:0][7:0]  n_window;
    logic                           r_urgent;
    logic                           n_urgent;
    logic                           r_caution;
    logic                           n_caution;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [1:0]                     r_out_sev;
    logic [1:0]                     n_out_sev;
    logic                           out_free;
    logic                           a_go;
    logic                           in_take;
    kss_pkg::t_hits                 hits;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_go       = r_a_valid && (!r_a_last || out_free);
    assign o_in_stall = r_a_valid && !a_go;
    assign in_take    = i_in_valid && !o_in_stall;

    kss_match u_match (
        .i_cur    (r_a_char),
        .i_window (r_window[kss_pkg::TERM_MAX-2:0]),
        .o_hits   (hits)
    );

    always_comb begin
        logic urg;
        logic cau;
        urg         = r_urgent;
        cau         = r_caution;
        n_window    = r_window;
        n_urgent    = r_urgent;
        n_caution   = r_caution;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_sev   = r_out_sev;
        if (a_go) begin
            if (r_a_has) begin
                urg      = r_urgent || hits.urgent;
                cau      = r_caution || hits.caution;
                n_window = {r_window[HISTORY_DEPTH-2:0], r_a_char};
            end
            n_urgent  = urg;
            n_caution = cau;
            if (r_a_last) begin
                n_out_valid = 1'b1;
                n_out_sev   = urg ? kss_pkg::SEV_URGENT :
                              (cau ? kss_pkg::SEV_CAUTION : kss_pkg::SEV_OK);
                // drop the string's history and flags
                n_window    = '0;
                n_urgent    = 1'b0;
                n_caution   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_window    <= '0;
            r_urgent    <= 1'b0;
            r_caution   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_a_valid <= i_in_valid;
            end
            r_window    <= n_window;
            r_urgent    <= n_urgent;
            r_caution   <= n_caution;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_char <= kss_pkg::fold_byte(i_character);
            r_a_has  <= i_has_character;
            r_a_last <= i_last;
        end
        r_out_sev <= n_out_sev;
    end

    assign o_out_valid = r_out_valid;
    assign o_severity  = r_out_sev;

    `KSS_ASSERT_NEXT(a_end_clears, a_go && r_a_last, r_window == '0 && !r_urgent && !r_caution)
    `KSS_ASSERT_NEXT(a_urgent_sticky, r_urgent && !(a_go && r_a_last), r_urgent)
    `KSS_ASSERT_SAME(a_mid_no_stall, r_a_valid && !r_a_last, !o_in_stall)

endmodule

`default_nettype wire

// ----- tb/keyword_severity_scanner_top_tb.sv -----
// Self-checking testbench for the keyword severity scanner: byte stream in, severity per string out.
`timescale 1ns / 100ps

module keyword_severity_scanner_top_tb;

    localparam int HIST       = 14;
    localparam int KW_N       = 11;
    localparam int URGENT_N   = 6;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } t_scan_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_character = 8'h00;
    logic       i_has_character = 1'b0;
    logic       i_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_severity;

    keyword_severity_scanner_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_character     (i_character),
        .i_has_character (i_has_character),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_severity      (o_severity)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // keyword list: urgent terms first
    string      kw_text [KW_N];
    logic [7:0] recent_bytes [HIST];
    logic       urgent_hit;
    logic       caution_hit;

    t_scan_word words_to_send [$];
    logic [1:0] severity_due [$];
    logic [7:0] text_buf [$];

    t_scan_word drv_word;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         mode_age = 0;
    int         stall_run = 0;
    int         idle_cycles = 0;
    int         errors = 0;
    int         words_queued = 0;
    int         strings_made = 0;
    int         n_ok = 0;
    int         n_caution = 0;
    int         n_urgent = 0;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    endfunction

    // does keyword t finish on the current folded byte?
    function automatic bit term_ends_here(input int t, input logic [7:0] cur);
        string s;
        int    n;
        int    k;
        s = kw_text[t];
        n = s.len();
        if (s[n-1] != cur) return 1'b0;
        for (k = 1; k < n; k++) begin
            if (s[n-1-k] != recent_bytes[k-1]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_scan();
        int k;
        for (k = 0; k < HIST; k++) recent_bytes[k] = 8'h00;
        urgent_hit  = 1'b0;
        caution_hit = 1'b0;
    endtask

    task automatic grade_word(input t_scan_word w);
        logic [7:0] cur;
        int         t;
        int         k;
        if (w.has) begin
            cur = fold_case(w.ch);
            for (t = 0; t < KW_N; t++) begin
                if (term_ends_here(t, cur)) begin
                    if (t < URGENT_N) urgent_hit = 1'b1;
                    else caution_hit = 1'b1;
                end
            end
            for (k = HIST - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
            recent_bytes[0] = cur;
        end
        if (w.last) begin
            severity_due.push_back(urgent_hit ? kss_pkg::SEV_URGENT :
                                   (caution_hit ? kss_pkg::SEV_CAUTION : kss_pkg::SEV_OK));
            clear_scan();
        end
    endtask

    task automatic push_word(input logic [7:0] ch, input logic has, input logic last);
        t_scan_word w;
        w.ch   = ch;
        w.has  = has;
        w.last = last;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // send text_buf as one string; marker_pos puts an empty word after that byte
    task automatic emit_text(input bit end_marker, input int marker_pos, input bit noisy);
        int i;
        int n;
        n = text_buf.size();
        for (i = 0; i < n; i++) begin
            push_word(text_buf[i], 1'b1, !end_marker && (i == n - 1));
            if (i == marker_pos || (noisy && $urandom_range(0, 11) == 0))
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        if (end_marker || n == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        text_buf.delete();
        strings_made++;
    endtask

    task automatic add_filler(input int n);
        string pool;
        int    i;
        int    pick;
        pool = "abcdeghilnoprstuv '";
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            else if (pick < 8) text_buf.push_back(8'($urandom_range(8'h41, 8'h5a)));
            else text_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // keyword in random case, now and then damaged into a near miss
    task automatic add_keyword();
        string      s;
        int         i;
        int         cut;
        int         damage;
        logic [7:0] c;
        s      = kw_text[$urandom_range(0, KW_N - 1)];
        cut    = $urandom_range(0, s.len() - 1);
        damage = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'h20;
            if (damage != 0 && i == cut) begin
                if (damage == 1) c = 8'h00;
                else if (damage == 2) c = 8'($urandom_range(8'h61, 8'h7a));
                else break;
            end
            text_buf.push_back(c);
        end
    endtask

    // driver: bursts of words with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) grade_word(drv_word);
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0 || words_to_send.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    drv_word = words_to_send.pop_front();
                    i_character     <= drv_word.ch;
                    i_has_character <= drv_word.has;
                    i_last          <= drv_word.last;
                    i_in_valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [1:0] e, input logic [1:0] a);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected severity %0d, got %0d", $time, what, e, a);
    endtask

    // monitor: check each taken result, then pick the next stall value
    always @(posedge i_clk) begin
        logic [1:0] want;
        logic       nxt;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (severity_due.size() == 0) begin
                    note_mismatch("unexpected result", 2'bxx, o_severity);
                end else begin
                    want = severity_due.pop_front();
                    if (o_severity !== want) note_mismatch("severity mismatch", want, o_severity);
                    if (want == kss_pkg::SEV_URGENT) n_urgent++;
                    else if (want == kss_pkg::SEV_CAUTION) n_caution++;
                    else n_ok++;
                end
            end
            if (mode_age == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_age   = $urandom_range(20, 80);
            end else begin
                mode_age--;
            end
            nxt = i_out_stall;
            if (stall_mode == 0) begin
                nxt = 1'b0;
            end else if (stall_mode == 1) begin
                nxt = ($urandom_range(0, 2) == 0);
            end else if (stall_run > 0) begin
                stall_run--;
            end else begin
                nxt       = !i_out_stall;
                stall_run = $urandom_range(0, 7);
            end
            i_out_stall <= nxt;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int base;
        kw_text[0]  = "chest pain";
        kw_text[1]  = "suicidal";
        kw_text[2]  = "overdose";
        kw_text[3]  = "can't breathe";
        kw_text[4]  = "cannot breathe";
        kw_text[5]  = "stroke";
        kw_text[6]  = "diagnose";
        kw_text[7]  = "prescribe";
        kw_text[8]  = "stop medication";
        kw_text[9]  = "dosage";
        kw_text[10] = "pregnant";
        clear_scan();

        // empty string, then a caution word ending on its last byte with an empty word inside
        emit_text(1'b1, -1, 1'b0);
        put_str("DOSAGE");
        emit_text(1'b0, 2, 1'b0);
        // a keyword split over two strings must not match
        put_str("str");
        emit_text(1'b1, -1, 1'b0);
        put_str("oke");
        emit_text(1'b0, -1, 1'b0);
        // byte extremes and the edges of the case fold
        text_buf = '{8'hff, 8'h00, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h41, 8'h5a};
        emit_text(1'b0, -1, 1'b0);

        base = words_queued;
        while (words_queued - base < 450) begin
            if ($urandom_range(0, 19) != 0) begin
                repeat ($urandom_range(0, 2)) begin
                    add_filler($urandom_range(0, 5));
                    add_keyword();
                end
                add_filler($urandom_range(0, 4));
            end
            emit_text($urandom_range(0, 3) == 0, -1, 1'b1);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (idle_cycles < IDLE_LIMIT &&
               (words_to_send.size() != 0 || i_in_valid || severity_due.size() != 0))
            @(posedge i_clk);

        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d words unsent, %0d results outstanding",
                     words_to_send.size(), severity_due.size());
            $display("[FAIL] regression broken");
        end else begin
            repeat (DRAIN) @(posedge i_clk);
            if (severity_due.size() != 0) begin
                errors++;
                $display("%0d results never arrived", severity_due.size());
            end
            $display("Scanned %0d strings in %0d words (empty words included).",
                     strings_made, words_queued);
            $display("Results: %0d ok, %0d caution, %0d urgent; %0d mismatches.",
                     n_ok, n_caution, n_urgent, errors);
            if (errors == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kss_pkg.sv
rtl/kss_match.sv
rtl/keyword_severity_scanner_top.sv
tb/keyword_severity_scanner_top_tb.sv
